// File: hdl/sfpr_pkg.sv
// Shared constants for the sync-framed packet receiver.
// No dependencies; used by sync_framed_packet_receiver.
package sfpr_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned POS_W   = 9;
    localparam int unsigned TYPE_W  = 2;
    localparam int unsigned CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_ONE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_TWO    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_THREE  = 3'd4;

    // Register reset values
    localparam logic [BYTE_W-1:0] RST_SYNC_FIRST  = 8'h75;
    localparam logic [BYTE_W-1:0] RST_SYNC_SECOND = 8'h65;
    localparam logic [BYTE_W-1:0] RST_TYPE_ONE    = 8'h80;
    localparam logic [BYTE_W-1:0] RST_TYPE_TWO    = 8'h82;
    localparam logic [BYTE_W-1:0] RST_TYPE_THREE  = 8'h91;

    // Header positions within a frame
    localparam logic [POS_W-1:0] POS_SYNC_FIRST  = 9'd0;
    localparam logic [POS_W-1:0] POS_SYNC_SECOND = 9'd1;
    localparam logic [POS_W-1:0] POS_DESCRIPTOR  = 9'd2;
    localparam logic [POS_W-1:0] POS_LENGTH      = 9'd3;

    // Frame type codes
    localparam logic [TYPE_W-1:0] TYPE_NONE  = 2'd0;
    localparam logic [TYPE_W-1:0] TYPE_ONE   = 2'd1;
    localparam logic [TYPE_W-1:0] TYPE_TWO   = 2'd2;
    localparam logic [TYPE_W-1:0] TYPE_THREE = 2'd3;

    // Check bytes trailing the payload
    localparam logic [POS_W-1:0] CHECK_BYTES = 9'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic [POS_W-1:0]  byte_position;
        logic [TYPE_W-1:0] frame_type;
        logic              end_of_frame;
        logic              checksum_ok;
    } t_result;

endpackage

// File: hdl/sync_framed_packet_receiver.sv
// Sync-framed packet receiver with a two-sum Fletcher-style check, sums modulo 256.
// Depends on sfpr_pkg for widths, register indexes and reset values.
//
// Channel  Direction  Handshake           Payload
// rx       in         i_valid / o_stall   i_rx_byte
// frame    out        o_valid / i_stall   o_frame_byte, o_byte_position, o_frame_type,
//                                         o_end_of_frame, o_checksum_ok
// cfg      in         i_cfg_wr_en         i_cfg_index, i_cfg_data
//
// One byte a cycle sustained while i_stall stays low; a byte taken passes through the input
// register, then the frame decode into the result register.
// Bytes that are rejected (bad sync or descriptor) give no result.
// Reset is synchronous and active low; it restores the register defaults and hunting.
// o_stall rises only when the input register is full and the result register is held
// by i_stall, so the result register doubles as the skid between the two sides.
module sync_framed_packet_receiver (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [sfpr_pkg::BYTE_W-1:0]       i_rx_byte,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [sfpr_pkg::BYTE_W-1:0]       o_frame_byte,
    output logic [sfpr_pkg::POS_W-1:0]        o_byte_position,
    output logic [sfpr_pkg::TYPE_W-1:0]       o_frame_type,
    output logic                              o_end_of_frame,
    output logic                              o_checksum_ok,
    input  logic                              i_cfg_wr_en,
    input  logic [sfpr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sfpr_pkg::BYTE_W-1:0]       i_cfg_data
);

    // configuration
    logic [sfpr_pkg::BYTE_W-1:0] r_sync_first;
    logic [sfpr_pkg::BYTE_W-1:0] r_sync_second;
    logic [sfpr_pkg::BYTE_W-1:0] r_type_one;
    logic [sfpr_pkg::BYTE_W-1:0] r_type_two;
    logic [sfpr_pkg::BYTE_W-1:0] r_type_three;

    // input register
    logic                        r_in_valid;
    logic [sfpr_pkg::BYTE_W-1:0] r_in_byte;

    // frame state
    logic [sfpr_pkg::POS_W-1:0]  r_pos,  n_pos;
    logic [sfpr_pkg::POS_W-1:0]  r_rem,  n_rem;
    logic [sfpr_pkg::TYPE_W-1:0] r_kind, n_kind;
    logic [sfpr_pkg::BYTE_W-1:0] r_sum_lo, n_sum_lo;
    logic [sfpr_pkg::BYTE_W-1:0] r_sum_hi, n_sum_hi;
    logic [sfpr_pkg::BYTE_W-1:0] r_first_check, n_first_check;

    // result register
    logic                  r_out_valid;
    sfpr_pkg::t_result     r_out;

    logic                        out_free;
    logic                        advance;
    logic                        res_valid;
    sfpr_pkg::t_result           res;
    logic                        hunt;
    logic                        add_sum;
    logic [sfpr_pkg::BYTE_W-1:0] sum_lo_add;
    logic [sfpr_pkg::BYTE_W-1:0] sum_hi_add;
    logic [sfpr_pkg::POS_W-1:0]  rem_dec;

    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= sfpr_pkg::RST_SYNC_FIRST;
            r_sync_second <= sfpr_pkg::RST_SYNC_SECOND;
            r_type_one    <= sfpr_pkg::RST_TYPE_ONE;
            r_type_two    <= sfpr_pkg::RST_TYPE_TWO;
            r_type_three  <= sfpr_pkg::RST_TYPE_THREE;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                sfpr_pkg::CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data;
                sfpr_pkg::CFG_SYNC_SECOND: r_sync_second <= i_cfg_data;
                sfpr_pkg::CFG_TYPE_ONE:    r_type_one    <= i_cfg_data;
                sfpr_pkg::CFG_TYPE_TWO:    r_type_two    <= i_cfg_data;
                sfpr_pkg::CFG_TYPE_THREE:  r_type_three  <= i_cfg_data;
                default: ;   // drop writes beyond the register list
            endcase
        end
    end

    // input register: load whenever it is empty or moving on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    assign sum_lo_add = r_sum_lo + r_in_byte;
    assign sum_hi_add = r_sum_hi + sum_lo_add;
    assign rem_dec    = r_rem - sfpr_pkg::POS_W'(1);

    always_comb begin
        n_pos         = r_pos;
        n_rem         = r_rem;
        n_kind        = r_kind;
        n_sum_lo      = r_sum_lo;
        n_sum_hi      = r_sum_hi;
        n_first_check = r_first_check;
        hunt          = 1'b0;
        add_sum       = 1'b0;
        res_valid     = 1'b0;
        res.frame_byte    = r_in_byte;
        res.byte_position = r_pos;
        res.frame_type    = r_kind;
        res.end_of_frame  = 1'b0;
        res.checksum_ok   = 1'b0;

        unique case (r_pos)
            sfpr_pkg::POS_SYNC_FIRST: begin
                res.frame_type = sfpr_pkg::TYPE_NONE;
                if (r_in_byte != r_sync_first) begin
                    hunt = 1'b1;
                end else begin
                    add_sum   = 1'b1;
                    n_pos     = sfpr_pkg::POS_SYNC_SECOND;
                    res_valid = 1'b1;
                end
            end
            sfpr_pkg::POS_SYNC_SECOND: begin
                res.frame_type = sfpr_pkg::TYPE_NONE;
                if (r_in_byte != r_sync_second) begin
                    hunt = 1'b1;
                end else begin
                    add_sum   = 1'b1;
                    n_pos     = sfpr_pkg::POS_DESCRIPTOR;
                    res_valid = 1'b1;
                end
            end
            sfpr_pkg::POS_DESCRIPTOR: begin
                // type one wins over two, two over three
                priority if (r_in_byte == r_type_one) begin
                    n_kind = sfpr_pkg::TYPE_ONE;
                end else if (r_in_byte == r_type_two) begin
                    n_kind = sfpr_pkg::TYPE_TWO;
                end else if (r_in_byte == r_type_three) begin
                    n_kind = sfpr_pkg::TYPE_THREE;
                end else begin
                    hunt = 1'b1;
                end
                if (!hunt) begin
                    add_sum   = 1'b1;
                    n_pos     = sfpr_pkg::POS_LENGTH;
                    res_valid = 1'b1;
                end
                res.frame_type = n_kind;
            end
            sfpr_pkg::POS_LENGTH: begin
                n_rem     = {1'b0, r_in_byte} + sfpr_pkg::CHECK_BYTES;
                add_sum   = 1'b1;
                n_pos     = r_pos + sfpr_pkg::POS_W'(1);
                res_valid = 1'b1;
            end
            default: begin
                // body: payload, then first and second check byte
                if (r_rem == '0) begin
                    hunt = 1'b1;
                end else begin
                    n_rem     = rem_dec;
                    res_valid = 1'b1;
                    if (rem_dec >= sfpr_pkg::CHECK_BYTES) begin
                        add_sum = 1'b1;
                        n_pos   = r_pos + sfpr_pkg::POS_W'(1);
                    end else if (rem_dec == sfpr_pkg::POS_W'(1)) begin
                        n_first_check = r_in_byte;
                        n_pos         = r_pos + sfpr_pkg::POS_W'(1);
                    end else begin
                        res.end_of_frame = 1'b1;
                        res.checksum_ok  = (r_sum_lo == r_first_check) &&
                                           (r_sum_hi == r_in_byte);
                        hunt = 1'b1;
                    end
                end
            end
        endcase

        if (add_sum) begin
            n_sum_lo = sum_lo_add;
            n_sum_hi = sum_hi_add;
        end
        if (hunt) begin
            n_pos    = sfpr_pkg::POS_SYNC_FIRST;
            n_rem    = '0;
            n_kind   = sfpr_pkg::TYPE_NONE;
            n_sum_lo = '0;
            n_sum_hi = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= sfpr_pkg::POS_SYNC_FIRST;
            r_rem         <= '0;
            r_kind        <= sfpr_pkg::TYPE_NONE;
            r_sum_lo      <= '0;
            r_sum_hi      <= '0;
            r_first_check <= '0;
        end else if (advance) begin
            r_pos         <= n_pos;
            r_rem         <= n_rem;
            r_kind        <= n_kind;
            r_sum_lo      <= n_sum_lo;
            r_sum_hi      <= n_sum_hi;
            r_first_check <= n_first_check;
        end
    end

    // result register: hold while the downstream side stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_frame_byte    = r_out.frame_byte;
    assign o_byte_position = r_out.byte_position;
    assign o_frame_type    = r_out.frame_type;
    assign o_end_of_frame  = r_out.end_of_frame;
    assign o_checksum_ok   = r_out.checksum_ok;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for sync_framed_packet_receiver: frames, rejects and checksum errors.
// Depends on sfpr_pkg and the receiver RTL; holds its own deframer and checksum predictor.
module testbench;

    localparam int unsigned NUM_REGS       = 5;
    localparam int unsigned RESET_CYCLES   = 7;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned HOLD_CYCLES    = 64;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned FULL_FRAME     = 1000;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_valid     = 1'b0;
    logic [sfpr_pkg::BYTE_W-1:0]    i_rx_byte   = '0;
    logic                           i_stall     = 1'b0;
    logic                           i_cfg_wr_en = 1'b0;
    logic [sfpr_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [sfpr_pkg::BYTE_W-1:0]    i_cfg_data  = '0;

    logic                           o_stall;
    logic                           o_valid;
    logic [sfpr_pkg::BYTE_W-1:0]    o_frame_byte;
    logic [sfpr_pkg::POS_W-1:0]     o_byte_position;
    logic [sfpr_pkg::TYPE_W-1:0]    o_frame_type;
    logic                           o_end_of_frame;
    logic                           o_checksum_ok;

    // Predictor state and register shadow
    logic [sfpr_pkg::BYTE_W-1:0]    cfg_reg [NUM_REGS];
    logic [sfpr_pkg::POS_W-1:0]     frm_pos;
    logic [sfpr_pkg::POS_W-1:0]     frm_left;
    logic [sfpr_pkg::TYPE_W-1:0]    frm_kind;
    logic [sfpr_pkg::BYTE_W-1:0]    sum_lo;
    logic [sfpr_pkg::BYTE_W-1:0]    sum_hi;
    logic [sfpr_pkg::BYTE_W-1:0]    chk_first;

    sfpr_pkg::t_result    expected_frames[$];
    sfpr_pkg::t_result    want;
    int unsigned          n_errors     = 0;
    int unsigned          n_framed     = 0;
    int unsigned          idle_cycles  = 0;
    bit                   tx_gaps_on   = 1'b1;
    bit                   rx_gaps_on   = 1'b1;
    bit                   hold_off_req = 1'b0;

    sync_framed_packet_receiver dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_frame_byte    (o_frame_byte),
        .o_byte_position (o_byte_position),
        .o_frame_type    (o_frame_type),
        .o_end_of_frame  (o_end_of_frame),
        .o_checksum_ok   (o_checksum_ok),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic void fletcher_add(inout logic [sfpr_pkg::BYTE_W-1:0] lo,
                                         inout logic [sfpr_pkg::BYTE_W-1:0] hi,
                                         input logic [sfpr_pkg::BYTE_W-1:0] b);
        lo = lo + b;
        hi = hi + lo;
    endfunction

    function automatic void restart_hunt();
        frm_pos  = sfpr_pkg::POS_SYNC_FIRST;
        frm_left = '0;
        frm_kind = sfpr_pkg::TYPE_NONE;
        sum_lo   = '0;
        sum_hi   = '0;
    endfunction

    // Advance the deframer by one byte; return 1 when the byte yields a result
    function automatic bit deframe_byte(input logic [sfpr_pkg::BYTE_W-1:0] b,
                                        output sfpr_pkg::t_result r);
        logic [sfpr_pkg::POS_W-1:0] pos;
        pos             = frm_pos;
        r               = '0;
        r.frame_byte    = b;
        r.byte_position = pos;
        if (pos == sfpr_pkg::POS_SYNC_FIRST) begin
            if (b != cfg_reg[sfpr_pkg::CFG_SYNC_FIRST]) begin
                restart_hunt();
                return 1'b0;
            end
        end else if (pos == sfpr_pkg::POS_SYNC_SECOND) begin
            if (b != cfg_reg[sfpr_pkg::CFG_SYNC_SECOND]) begin
                restart_hunt();
                return 1'b0;
            end
        end else if (pos == sfpr_pkg::POS_DESCRIPTOR) begin
            // lower type number wins when codes coincide
            if (b == cfg_reg[sfpr_pkg::CFG_TYPE_ONE]) frm_kind = sfpr_pkg::TYPE_ONE;
            else if (b == cfg_reg[sfpr_pkg::CFG_TYPE_TWO]) frm_kind = sfpr_pkg::TYPE_TWO;
            else if (b == cfg_reg[sfpr_pkg::CFG_TYPE_THREE]) frm_kind = sfpr_pkg::TYPE_THREE;
            else begin
                restart_hunt();
                return 1'b0;
            end
        end else if (pos == sfpr_pkg::POS_LENGTH) begin
            frm_left = sfpr_pkg::POS_W'(b) + sfpr_pkg::CHECK_BYTES;
        end else begin
            if (frm_left == '0) begin
                restart_hunt();
                return 1'b0;
            end
            frm_left = frm_left - 1'b1;
            if (frm_left >= sfpr_pkg::CHECK_BYTES) begin
                fletcher_add(sum_lo, sum_hi, b);
            end else if (frm_left == 1) begin
                chk_first = b;
            end else begin
                r.frame_type    = frm_kind;
                r.end_of_frame  = 1'b1;
                r.checksum_ok   = (sum_lo == chk_first) && (sum_hi == b);
                restart_hunt();
                return 1'b1;
            end
        end
        if (pos <= sfpr_pkg::POS_LENGTH) fletcher_add(sum_lo, sum_hi, b);
        r.frame_type = frm_kind;
        frm_pos      = pos + 1'b1;
        return 1'b1;
    endfunction

    task automatic send_byte(input logic [sfpr_pkg::BYTE_W-1:0] b);
        int unsigned       gap;
        sfpr_pkg::t_result r;
        gap = tx_gaps_on ? gap_len() : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        if (deframe_byte(b, r)) begin
            expected_frames.push_back(r);
            n_framed++;
        end
    endtask

    // Build a frame from the live register values; corrupt flips check bytes,
    // cut truncates the frame after that many bytes
    task automatic send_frame(input logic [sfpr_pkg::TYPE_W-1:0] kind,
                              input int unsigned len,
                              input logic [1:0] corrupt, input int unsigned cut);
        logic [sfpr_pkg::BYTE_W-1:0] frame_bytes[$];
        logic [sfpr_pkg::BYTE_W-1:0] lo;
        logic [sfpr_pkg::BYTE_W-1:0] hi;
        lo = '0;
        hi = '0;
        frame_bytes.push_back(cfg_reg[sfpr_pkg::CFG_SYNC_FIRST]);
        frame_bytes.push_back(cfg_reg[sfpr_pkg::CFG_SYNC_SECOND]);
        frame_bytes.push_back(cfg_reg[sfpr_pkg::CFG_IDX_W'(sfpr_pkg::CFG_TYPE_ONE + kind
                                                           - sfpr_pkg::TYPE_ONE)]);
        frame_bytes.push_back(sfpr_pkg::BYTE_W'(len));
        repeat (len) frame_bytes.push_back(sfpr_pkg::BYTE_W'($urandom));
        foreach (frame_bytes[i]) fletcher_add(lo, hi, frame_bytes[i]);
        frame_bytes.push_back(corrupt[0] ?
                              lo ^ sfpr_pkg::BYTE_W'($urandom_range(1, 255)) : lo);
        frame_bytes.push_back(corrupt[1] ?
                              hi ^ sfpr_pkg::BYTE_W'($urandom_range(1, 255)) : hi);
        foreach (frame_bytes[i]) begin
            if (i < cut) send_byte(frame_bytes[i]);
        end
    endtask

    // Drop valid and wait until every result is out and rejected bytes have cleared
    task automatic settle();
        i_valid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // vals packs the registers by index, lowest byte first; a stray index follows
    task automatic load_config(input logic [NUM_REGS*sfpr_pkg::BYTE_W-1:0] vals);
        settle();
        for (int i = sfpr_pkg::CFG_SYNC_FIRST; i <= sfpr_pkg::CFG_TYPE_THREE; i++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= sfpr_pkg::CFG_IDX_W'(i);
            i_cfg_data  <= vals[i*sfpr_pkg::BYTE_W +: sfpr_pkg::BYTE_W];
            @(posedge i_clk);
            cfg_reg[i] = vals[i*sfpr_pkg::BYTE_W +: sfpr_pkg::BYTE_W];
        end
        // out-of-range index must leave every register alone
        i_cfg_index <= sfpr_pkg::CFG_IDX_W'($urandom_range(NUM_REGS,
                                                           (1 << sfpr_pkg::CFG_IDX_W) - 1));
        i_cfg_data  <= sfpr_pkg::BYTE_W'($urandom);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_traffic(input int unsigned n_results);
        int unsigned                 stop_at;
        int unsigned                 pick;
        int unsigned                 len;
        logic [sfpr_pkg::TYPE_W-1:0] kind;
        stop_at = n_framed + n_results;
        while (n_framed < stop_at) begin
            pick = $urandom_range(99);
            kind = sfpr_pkg::TYPE_W'($urandom_range(sfpr_pkg::TYPE_ONE, sfpr_pkg::TYPE_THREE));
            len  = $urandom_range(99);
            if (len < 85) len = $urandom_range(0, 6);
            else if (len < 98) len = $urandom_range(7, 40);
            else len = 255;
            if (pick < 70) begin
                send_frame(kind, len, 2'b00, FULL_FRAME);
            end else if (pick < 80) begin
                send_frame(kind, len, 2'($urandom_range(1, 3)), FULL_FRAME);
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 4)) send_byte(sfpr_pkg::BYTE_W'($urandom));
            end else if (pick < 94) begin
                send_byte(cfg_reg[sfpr_pkg::CFG_SYNC_FIRST]);
                send_byte(sfpr_pkg::BYTE_W'($urandom));
            end else begin
                send_frame(kind, len, 2'b00, $urandom_range(1, len + 5));
            end
        end
    endtask

    task automatic test_frame_types();
        send_frame(sfpr_pkg::TYPE_ONE, 0, 2'b00, FULL_FRAME);
        send_frame(sfpr_pkg::TYPE_TWO, 0, 2'b01, FULL_FRAME);
        send_frame(sfpr_pkg::TYPE_THREE, 0, 2'b10, FULL_FRAME);
    endtask

    task automatic test_rejects();
        send_byte(8'h00);
        send_byte(8'hFF);
        // second sync fails; the failing byte must not restart the hunt
        send_byte(cfg_reg[sfpr_pkg::CFG_SYNC_FIRST]);
        send_byte(cfg_reg[sfpr_pkg::CFG_SYNC_FIRST]);
        send_byte(cfg_reg[sfpr_pkg::CFG_SYNC_SECOND]);
        // unknown descriptor
        send_byte(cfg_reg[sfpr_pkg::CFG_SYNC_FIRST]);
        send_byte(cfg_reg[sfpr_pkg::CFG_SYNC_SECOND]);
        send_byte(cfg_reg[sfpr_pkg::CFG_TYPE_ONE] ^ 8'h01);
    endtask

    task automatic test_register_extremes();
        load_config('0);
        run_traffic(80);
        load_config('1);
        run_traffic(80);
    endtask

    task automatic test_code_priority();
        logic [sfpr_pkg::BYTE_W-1:0] sync_val;
        logic [sfpr_pkg::BYTE_W-1:0] code_val;
        sync_val = sfpr_pkg::BYTE_W'($urandom);
        code_val = sfpr_pkg::BYTE_W'($urandom);
        load_config({code_val, code_val, code_val, sync_val, sync_val});
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        run_traffic(50);
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        load_config({sfpr_pkg::BYTE_W'($urandom), code_val, code_val,
                     sfpr_pkg::BYTE_W'($urandom), sync_val});
        run_traffic(30);
    endtask

    task automatic test_backpressure();
        tx_gaps_on   = 1'b0;
        hold_off_req = 1'b1;
        send_frame(sfpr_pkg::TYPE_TWO, 30, 2'b00, FULL_FRAME);
        tx_gaps_on   = 1'b1;
    endtask

    task automatic test_random_configs();
        repeat (3) begin
            load_config({$urandom, sfpr_pkg::BYTE_W'($urandom)});
            run_traffic(80);
        end
    endtask

    initial begin
        cfg_reg[sfpr_pkg::CFG_SYNC_FIRST]  = sfpr_pkg::RST_SYNC_FIRST;
        cfg_reg[sfpr_pkg::CFG_SYNC_SECOND] = sfpr_pkg::RST_SYNC_SECOND;
        cfg_reg[sfpr_pkg::CFG_TYPE_ONE]    = sfpr_pkg::RST_TYPE_ONE;
        cfg_reg[sfpr_pkg::CFG_TYPE_TWO]    = sfpr_pkg::RST_TYPE_TWO;
        cfg_reg[sfpr_pkg::CFG_TYPE_THREE]  = sfpr_pkg::RST_TYPE_THREE;
        chk_first = '0;
        restart_hunt();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_frame_types();
        test_rejects();
        test_register_extremes();
        test_code_priority();
        test_backpressure();
        test_random_configs();
        settle();
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin : rx_backpressure
        int unsigned n;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                n = rx_gaps_on ? gap_len() : 0;
                i_stall <= (n != 0);
                if (n > 1) repeat (n - 1) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_frames.size() == 0) begin
                $error("unexpected result: frame_byte %0h at position %0d",
                       o_frame_byte, o_byte_position);
                n_errors++;
            end else begin
                want = expected_frames.pop_front();
                if (o_frame_byte !== want.frame_byte) begin
                    $error("frame_byte: expected %0h, got %0h", want.frame_byte, o_frame_byte);
                    n_errors++;
                end
                if (o_byte_position !== want.byte_position) begin
                    $error("byte_position: expected %0d, got %0d",
                           want.byte_position, o_byte_position);
                    n_errors++;
                end
                if (o_frame_type !== want.frame_type) begin
                    $error("frame_type: expected %0d, got %0d", want.frame_type, o_frame_type);
                    n_errors++;
                end
                if (o_end_of_frame !== want.end_of_frame) begin
                    $error("end_of_frame: expected %0b, got %0b",
                           want.end_of_frame, o_end_of_frame);
                    n_errors++;
                end
                if (o_checksum_ok !== want.checksum_ok) begin
                    $error("checksum_ok: expected %0b, got %0b", want.checksum_ok, o_checksum_ok);
                    n_errors++;
                end
            end
        end
    end

    // Count cycles without any request moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
